// ===== rtl/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants for the sorted byte list.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Broadcast from the top level to every cell
    typedef struct packed
    {
        logic              wr_en;
        logic              is_delete;
        logic signed [7:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/sbl_if.sv =====
// ----------------------------------------------------------------------------
// sbl_if
// Request and response channels of the sorted byte list.
// ----------------------------------------------------------------------------
interface sbl_req_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic signed [7:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sbl_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [4:0]        entry_count;
    logic signed [7:0] smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

// ===== rtl/sbl_cell.sv =====
// ----------------------------------------------------------------------------
// sbl_cell
// One slot of the sorted list: compares against the request value and
// shifts toward its left or right neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sbl_cell
    import sbl_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic              valid,
    input  logic signed [7:0] left_val,
    input  logic signed [7:0] right_val,
    input  logic              left_gt,
    input  logic              found_in,
    output logic              gt,
    output logic              found_out,
    output logic signed [7:0] val,
    output logic signed [7:0] val_next
);

    logic signed [7:0] val_reg;
    logic              eq;

    assign gt        = valid && (ctl.value > val_reg);
    assign eq        = valid && (ctl.value == val_reg);
    assign found_out = found_in | eq;
    assign val       = val_reg;

    always_comb
    begin
        if (ctl.is_delete)
        begin
            // at or past the first match, pull from the right
            val_next = (found_in | eq) ? right_val : val_reg;
        end
        else if (gt)
        begin
            val_next = val_reg;
        end
        else
        begin
            // first cell not below the value takes it, the rest shift right
            val_next = left_gt ? ctl.value : left_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== rtl/sorted_byte_list.sv =====
// ----------------------------------------------------------------------------
// sorted_byte_list
// Bounded ascending list of signed bytes with insert and delete requests.
// ----------------------------------------------------------------------------
// All cells compare and shift together; the response is registered.
// Throughput: one request per cycle unless a response waits on rsp.ready.
// Reset: entry count and response valid clear asynchronously on rst_n low;
// cell contents are unspecified until written and need no clearing pass.
module sorted_byte_list
    import sbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sbl_req_if.sink    req,
    sbl_rsp_if.source  rsp
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [4:0]        entry_count_reg;
    logic signed [7:0] smallest_reg;
    logic signed [7:0] smallest_next;
    logic [CNT_W+4:0]  count_wide;

    logic              fire;
    logic              is_delete;
    logic              full;
    logic              do_ins;
    logic              do_del;
    cell_ctl_t         ctl;

    logic signed [7:0] val      [CAPACITY];
    logic signed [7:0] val_next [CAPACITY];
    logic              gt       [CAPACITY];
    logic              found    [CAPACITY+1];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_delete = (req.opcode == OP_DELETE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_ins    = fire && !is_delete && !full;
    assign do_del    = fire && is_delete && found[CAPACITY];

    assign ctl.wr_en     = do_ins || do_del;
    assign ctl.is_delete = is_delete;
    assign ctl.value     = req.value;

    assign found[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [7:0] lv;
            logic signed [7:0] rv;
            logic              lg;
            if (i == 0)
            begin : g_first
                assign lv = '0;
                assign lg = 1'b1;
            end
            else
            begin : g_mid
                assign lv = val[i-1];
                assign lg = gt[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign rv = '0;
            end
            else
            begin : g_inner
                assign rv = val[i+1];
            end

            sbl_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (CNT_W'(i) < count_reg),
                .left_val  (lv),
                .right_val (rv),
                .left_gt   (lg),
                .found_in  (found[i]),
                .gt        (gt[i]),
                .found_out (found[i+1]),
                .val       (val[i]),
                .val_next  (val_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_INSERTED;
        if (!is_delete)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (count_reg == '0)
        begin
            status_next = ST_EMPTY;
        end
        else if (found[CAPACITY])
        begin
            status_next = ST_DELETED;
            count_next  = count_reg - 1'b1;
        end
        else
        begin
            status_next = ST_NOTFOUND;
        end

        if (count_next == '0)
        begin
            smallest_next = '0;
        end
        else if (ctl.wr_en)
        begin
            smallest_next = val_next[0];
        end
        else
        begin
            smallest_next = val[0];
        end
    end

    assign count_wide = {5'd0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg      <= status_next;
            entry_count_reg <= count_wide[4:0];
            smallest_reg    <= smallest_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.smallest    = smallest_reg;

endmodule
